/* rtl/md5sh_pkg.sv */
// md5sh_pkg: shared types, constants and round tables for the md5 stream hasher
// no dependencies; used by md5sh_core, md5_stream_hasher and md5sh_checker
package md5sh_pkg;

  // one input transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } md5sh_in_t;

  // one result transaction
  typedef struct packed {
    logic [31:0] digest_word_a;
    logic [31:0] digest_word_b;
    logic [31:0] digest_word_c;
    logic [31:0] digest_word_d;
  } md5sh_out_t;

  // sequencer to round datapath controls
  typedef struct packed {
    logic       init_h;
    logic       load_abcd;
    logic       step;
    logic       add_h;
    logic [5:0] round;
  } md5sh_core_ctl_t;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam int unsigned WORDS    = 16;
  localparam int unsigned WORD_AW  = 4;
  localparam logic [3:0]  LEN_LO_WORD = 4'd14;
  localparam logic [3:0]  LEN_HI_WORD = 4'd15;

  // additive round constant
  function automatic logic [31:0] md5sh_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // left rotate amount
  function automatic logic [4:0] md5sh_s(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // message word index used by a round
  function automatic logic [3:0] md5sh_g(input logic [5:0] r);
    logic [3:0] g;
    case (r[5:4])
      2'd0:    g = r[3:0];
      2'd1:    g = 4'(r[3:0] * 4'd5 + 4'd1);
      2'd2:    g = 4'(r[3:0] * 4'd3 + 4'd5);
      default: g = 4'(r[3:0] * 4'd7);
    endcase
    return g;
  endfunction

endpackage

/* rtl/md5sh_ram.sv */
// md5sh_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module md5sh_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* rtl/md5sh_core.sv */
// md5sh_core: chaining words and the one-round-per-cycle md5 compression datapath
// depends on md5sh_pkg
module md5sh_core
  import md5sh_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  md5sh_core_ctl_t ctl_i,
  input  logic [31:0]     w_i,
  output md5sh_out_t      h_o
);

  logic [31:0] h0_q, h1_q, h2_q, h3_q;
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [31:0] f, sum, rot, b_d;
  logic [63:0] rot_wide;

  // round function by phase
  always_comb begin
    case (ctl_i.round[5:4])
      2'd0:    f = (b_q & c_q) | (~b_q & d_q);
      2'd1:    f = (b_q & d_q) | (c_q & ~d_q);
      2'd2:    f = b_q ^ c_q ^ d_q;
      default: f = c_q ^ (b_q | ~d_q);
    endcase
  end

  // add, rotate, add
  assign sum      = a_q + f + md5sh_k(ctl_i.round) + w_i;
  assign rot_wide = {sum, sum} << md5sh_s(ctl_i.round);
  assign rot      = rot_wide[63:32];
  assign b_d      = b_q + rot;

  // chaining words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h0_q <= IV_A;
      h1_q <= IV_B;
      h2_q <= IV_C;
      h3_q <= IV_D;
    end else if (ctl_i.init_h) begin
      h0_q <= IV_A;
      h1_q <= IV_B;
      h2_q <= IV_C;
      h3_q <= IV_D;
    end else if (ctl_i.add_h) begin
      h0_q <= h0_q + a_q;
      h1_q <= h1_q + b_q;
      h2_q <= h2_q + c_q;
      h3_q <= h3_q + d_q;
    end
  end

  // working variables
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_abcd) begin
      a_q <= h0_q;
      b_q <= h1_q;
      c_q <= h2_q;
      d_q <= h3_q;
    end else if (ctl_i.step) begin
      a_q <= d_q;
      b_q <= b_d;
      c_q <= b_q;
      d_q <= c_q;
    end
  end

  assign h_o.digest_word_a = h0_q;
  assign h_o.digest_word_b = h1_q;
  assign h_o.digest_word_c = h2_q;
  assign h_o.digest_word_d = h3_q;

endmodule

/* rtl/md5_stream_hasher.sv */
// md5_stream_hasher: md5 of a byte stream, block words kept in a 16x32 ram
// depends on md5sh_pkg, md5sh_ram, md5sh_core
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid_i/in_stall_o  | md5sh_in_t  (byte, has_byte, end)
//  out     | output    | out_valid_o/out_stall_i| md5sh_out_t (four digest words)
//
// a byte transaction is accepted while the block is idle; the 64th byte of a block adds a
// compression (ram read setup, 64 rounds of the shared round unit, final add)
// an end transaction costs up to 18 padding word writes, one or two compressions
// and a handover that moves the digest into the output register
// reset loads the chaining words with the iv and clears the byte count; the block ram needs no clearing
// a stalled result holds back the next digest handover, and input stays stalled while that handover waits
module md5_stream_hasher
  import md5sh_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  md5sh_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output md5sh_out_t out_data_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PADF  = 3'd1;
  localparam logic [2:0] ST_PADZ  = 3'd2;
  localparam logic [2:0] ST_CLOAD = 3'd3;
  localparam logic [2:0] ST_CRND  = 3'd4;
  localparam logic [2:0] ST_CADD  = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [60:0] cnt_q, cnt_d;
  logic [23:0] word_q, word_d;
  logic [3:0]  ptr_q, ptr_d;
  logic [5:0]  round_q, round_d;
  logic        pend_q, pend_d;
  logic        ovf_q, ovf_d;
  logic        final_q, final_d;
  logic        out_valid_q, out_valid_d;
  md5sh_out_t  out_q, out_d;

  logic                 ram_we;
  logic [WORD_AW-1:0]   ram_waddr, ram_raddr;
  logic [31:0]          ram_wdata, ram_rdata;
  md5sh_core_ctl_t      ctl;
  md5sh_out_t           h;
  logic [5:0]           fill;
  logic [63:0]          bit_len;

  assign fill    = cnt_q[5:0];
  assign bit_len = {cnt_q, 3'b000};

  // block word store
  md5sh_ram #(
    .Width(32),
    .Depth(WORDS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // round datapath
  md5sh_core u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (ctl),
    .w_i   (ram_rdata),
    .h_o   (h)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    word_d      = word_q;
    ptr_d       = ptr_q;
    round_d     = round_q;
    pend_d      = pend_q;
    ovf_d       = ovf_q;
    final_d     = final_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we      = 1'b0;
    ram_waddr   = fill[5:2];
    ram_wdata   = {in_data_i.data_byte, word_q};
    ram_raddr   = md5sh_g(round_q + 6'd1);
    ctl         = '0;
    ctl.round   = round_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.has_byte) begin
            // gather the byte into the current word
            case (fill[1:0])
              2'd0:    word_d[7:0]   = in_data_i.data_byte;
              2'd1:    word_d[15:8]  = in_data_i.data_byte;
              2'd2:    word_d[23:16] = in_data_i.data_byte;
              default: ram_we        = 1'b1;
            endcase
            cnt_d = cnt_q + 61'd1;
            if (fill == 6'd63) begin
              state_d = ST_CLOAD;
              pend_d  = in_data_i.end_of_message;
              final_d = 1'b0;
              ovf_d   = 1'b0;
            end else if (in_data_i.end_of_message) begin
              state_d = ST_PADF;
            end
          end else if (in_data_i.end_of_message) begin
            state_d = ST_PADF;
          end
        end
      end
      ST_PADF: begin
        // word with the marker byte, stale bytes above it cleared
        ram_we = 1'b1;
        case (fill[1:0])
          2'd0:    ram_wdata = {24'h0, PAD_BYTE};
          2'd1:    ram_wdata = {16'h0, PAD_BYTE, word_q[7:0]};
          2'd2:    ram_wdata = {8'h0, PAD_BYTE, word_q[15:0]};
          default: ram_wdata = {PAD_BYTE, word_q};
        endcase
        ovf_d   = (fill[5:2] >= LEN_LO_WORD);
        final_d = 1'b0;
        if (fill[5:2] == LEN_HI_WORD) begin
          state_d = ST_CLOAD;
        end else begin
          ptr_d   = fill[5:2] + 4'd1;
          state_d = ST_PADZ;
        end
      end
      ST_PADZ: begin
        // zero fill, bit length in the last two words of the final block
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        if (!ovf_q && ptr_q == LEN_LO_WORD) begin
          ram_wdata = bit_len[31:0];
        end else if (!ovf_q && ptr_q == LEN_HI_WORD) begin
          ram_wdata = bit_len[63:32];
        end else begin
          ram_wdata = 32'h0;
        end
        if (ptr_q == LEN_HI_WORD) begin
          state_d = ST_CLOAD;
          final_d = !ovf_q;
        end else begin
          ptr_d = ptr_q + 4'd1;
        end
      end
      ST_CLOAD: begin
        ram_raddr     = md5sh_g(6'd0);
        ctl.load_abcd = 1'b1;
        round_d       = 6'd0;
        state_d       = ST_CRND;
      end
      ST_CRND: begin
        ctl.step = 1'b1;
        round_d  = round_q + 6'd1;
        if (round_q == 6'd63) begin
          state_d = ST_CADD;
        end
      end
      ST_CADD: begin
        ctl.add_h = 1'b1;
        if (final_q) begin
          state_d = ST_DONE;
        end else if (ovf_q) begin
          ovf_d   = 1'b0;
          ptr_d   = 4'd0;
          state_d = ST_PADZ;
        end else if (pend_q) begin
          pend_d  = 1'b0;
          state_d = ST_PADF;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DONE: begin
        // hand the digest over and restart the hash
        if (!out_valid_q || !out_stall_i) begin
          out_d       = h;
          out_valid_d = 1'b1;
          ctl.init_h  = 1'b1;
          cnt_d       = '0;
          final_d     = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ptr_q       <= '0;
      round_q     <= '0;
      pend_q      <= 1'b0;
      ovf_q       <= 1'b0;
      final_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      round_q     <= round_d;
      pend_q      <= pend_d;
      ovf_q       <= ovf_d;
      final_q     <= final_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/md5sh_checker.sv */
// md5sh_checker: port-level assertions for the md5 stream hasher, bound to the top
// depends on md5sh_pkg and md5_stream_hasher
module md5sh_checker
  import md5sh_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_i,
  input md5sh_in_t  in_data_i,
  input logic       out_valid_i,
  input logic       out_stall_i,
  input md5sh_out_t out_data_i
);

  // a stalled result stays and holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed or dropped");

  // an end transaction always makes the block busy, with padding or with compressing a full block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i && in_data_i.end_of_message |=> in_stall_i)
    else $error("end transaction did not start padding");

  // an empty transaction leaves the block ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i && !in_data_i.has_byte && !in_data_i.end_of_message
    |=> !in_stall_i)
    else $error("empty transaction made the block busy");

  // a new result only appears after the block was busy finishing a message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_stall_i))
    else $error("result appeared while the block was accepting input");

endmodule

bind md5_stream_hasher md5sh_checker u_md5sh_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_i (in_stall_o),
  .in_data_i  (in_data_i),
  .out_valid_i(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_i (out_data_o)
);
